FILE: sv/aapr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package aapr_pkg;

  localparam int unsigned AtanEntries = 24;
  localparam int unsigned TurnUnits = 23040;
  localparam int unsigned HalfTurnUnits = 11520;
  localparam int unsigned QuarterTurnUnits = 5760;
  localparam logic signed [27:0] RadScale = 28'sd74961321;
  localparam logic signed [33:0] InvGainQ30 = 34'sd652032874;
  localparam logic signed [33:0] OneQ30 = 34'sd1073741824;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [15:0] angle;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] rotated_x;
    logic signed [31:0] rotated_y;
    logic signed [31:0] rotated_z;
    logic               saturated;
  } out_item_t;

  // Data handed from one CORDIC cell to the next.
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic               flip;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vz;
  } cordic_t;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
    logic signed [33:0] r;
    case (idx)
      5'd0: r = 34'sd843314856;
      5'd1: r = 34'sd497837829;
      5'd2: r = 34'sd263043836;
      5'd3: r = 34'sd133525158;
      5'd4: r = 34'sd67021686;
      5'd5: r = 34'sd33543515;
      5'd6: r = 34'sd16775850;
      5'd7: r = 34'sd8388437;
      5'd8: r = 34'sd4194282;
      5'd9: r = 34'sd2097149;
      5'd10: r = 34'sd1048575;
      5'd11: r = 34'sd524287;
      5'd12: r = 34'sd262143;
      5'd13: r = 34'sd131071;
      5'd14: r = 34'sd65535;
      5'd15: r = 34'sd32767;
      5'd16: r = 34'sd16383;
      5'd17: r = 34'sd8191;
      5'd18: r = 34'sd4095;
      5'd19: r = 34'sd2047;
      5'd20: r = 34'sd1023;
      5'd21: r = 34'sd511;
      5'd22: r = 34'sd255;
      5'd23: r = 34'sd127;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/axis_angle_point_rotation_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Rotates a Q16.16 point about a Q2.14 axis by an angle in 1/64 degree
// (Rodrigues' formula), one item per cycle while not stalled. The pipe holds
// one angle reduction stage, one CORDIC cell per step up to the atan table
// size, three matrix and product stages, and the output register. A stall
// freezes the whole pipe, so items hold in place and none is lost; the input
// stall mirrors the output stall while the output register is full.
module axis_angle_point_rotation_core #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_stall_o,
  input  wire aapr_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire                      out_stall_i,
  output aapr_pkg::out_item_t      out_item_o
);
  import aapr_pkg::*;

  localparam int unsigned Cells = (CORDIC_STEPS < AtanEntries) ? CORDIC_STEPS
                                                              : AtanEntries;

  logic    en;
  logic    acc_in;
  logic    vld  [Cells+1];
  cordic_t cd   [Cells+1];
  logic    r_valid_q;
  cordic_t r_q;

  // output register holds while stalled; the pipe advances when it can move
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;
  assign acc_in     = in_valid_i && en;

  // angle reduction into [-90, 90] degrees
  logic signed [16:0] a0, a1;
  logic               flip;
  logic signed [44:0] zp;
  cordic_t            r_d;
  always_comb begin
    a0 = 17'(in_item_i.angle);
    if (a0 < 0) a0 = a0 + 17'(TurnUnits);
    if (a0 < 0) a0 = a0 + 17'(TurnUnits);
    if (a0 >= 17'(TurnUnits)) a0 = a0 - 17'(TurnUnits);
    if (a0 > 17'(HalfTurnUnits)) a0 = a0 - 17'(TurnUnits);
    flip = 1'b0;
    a1 = a0;
    // a0 may be negative here, so compare signed
    if (a0 > $signed(17'(QuarterTurnUnits))) begin
      a1 = a0 - 17'(HalfTurnUnits);
      flip = 1'b1;
    end else if (a0 < -$signed(17'(QuarterTurnUnits))) begin
      a1 = a0 + 17'(HalfTurnUnits);
      flip = 1'b1;
    end
    zp = 45'(a1) * 45'(RadScale) + 45'sd128;
    r_d.x = InvGainQ30;
    r_d.y = '0;
    r_d.z = 34'(zp >>> 8);
    r_d.flip = flip;
    r_d.px = in_item_i.point_x;
    r_d.py = in_item_i.point_y;
    r_d.pz = in_item_i.point_z;
    r_d.vx = in_item_i.axis_x;
    r_d.vy = in_item_i.axis_y;
    r_d.vz = in_item_i.axis_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
    end else if (en) begin
      r_valid_q <= acc_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q <= r_d;
    end
  end

  assign vld[0] = r_valid_q;
  assign cd[0]  = r_q;

  for (genvar g = 0; g < Cells; g++) begin : g_cell
    aapr_cordic_cell #(.Step(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld[g]),
      .data_i  (cd[g]),
      .valid_o (vld[g+1]),
      .data_o  (cd[g+1])
    );
  end

  aapr_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld[Cells]),
    .data_i  (cd[Cells]),
    .valid_o (out_valid_o),
    .item_o  (out_item_o)
  );

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed under stall");
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");
  a_first_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld[0] && en |=> vld[1])
    else $error("item dropped in first cell");
`endif
endmodule
`default_nettype wire

FILE: sv/aapr_cordic_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One CORDIC micro-rotation by atan(2^-Step), registered.
module aapr_cordic_cell #(
  parameter int unsigned Step = 0
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     en_i,
  input  wire                     valid_i,
  input  wire aapr_pkg::cordic_t  data_i,
  output logic                    valid_o,
  output aapr_pkg::cordic_t       data_o
);
  import aapr_pkg::*;

  logic signed [33:0] dx, dy, at;
  cordic_t            data_d, data_q;
  logic               valid_q;

  assign dx = data_i.y >>> Step;
  assign dy = data_i.x >>> Step;
  assign at = atan_q30(5'(Step));

  always_comb begin
    data_d = data_i;
    if (!data_i.z[33]) begin
      data_d.x = data_i.x - dx;
      data_d.y = data_i.y + dy;
      data_d.z = data_i.z - at;
    end else begin
      data_d.x = data_i.x + dx;
      data_d.y = data_i.y - dy;
      data_d.z = data_i.z + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule
`default_nettype wire

FILE: sv/aapr_matrix.sv
`timescale 1ns / 1ps
`default_nettype none
// Rodrigues matrix and R*p, four register stages.
module aapr_matrix (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     en_i,
  input  wire                     valid_i,
  input  wire aapr_pkg::cordic_t  data_i,
  output logic                    valid_o,
  output aapr_pkg::out_item_t     item_o
);
  import aapr_pkg::*;

  logic [3:0] vld_q;

  // stage A: sin/cos, t, axis products
  logic signed [33:0] sn_d, cs_d, sn_q, cs_q, t_q;
  logic signed [31:0] vv_d [6], vv_q [6];
  logic signed [31:0] pa_q [3];
  logic signed [15:0] va_q [3];
  // stage B: matrix entries
  logic signed [35:0] m_d [9], m_q [9];
  logic signed [31:0] pb_q [3];
  // stage C: products (exact, 68 bits)
  logic signed [67:0] pr_q [9];
  // stage D: output
  out_item_t          item_q;

  assign sn_d = data_i.flip ? -data_i.y : data_i.y;
  assign cs_d = data_i.flip ? -data_i.x : data_i.x;
  assign vv_d[0] = 32'(data_i.vx * data_i.vx);
  assign vv_d[1] = 32'(data_i.vx * data_i.vy);
  assign vv_d[2] = 32'(data_i.vx * data_i.vz);
  assign vv_d[3] = 32'(data_i.vy * data_i.vy);
  assign vv_d[4] = 32'(data_i.vy * data_i.vz);
  assign vv_d[5] = 32'(data_i.vz * data_i.vz);

  function automatic logic signed [35:0] vvt(input logic signed [31:0] a,
                                             input logic signed [33:0] t);
    logic signed [65:0] p;
    p = 66'(a) * 66'(t) + 66'sd134217728;
    return 36'(p >>> 28);
  endfunction

  function automatic logic signed [35:0] vsn(input logic signed [15:0] a,
                                             input logic signed [33:0] s);
    logic signed [49:0] p;
    p = 50'(a) * 50'(s) + 50'sd8192;
    return 36'(p >>> 14);
  endfunction

  always_comb begin
    logic signed [35:0] s0, s1, s2, c;
    s0 = vsn(va_q[0], sn_q);
    s1 = vsn(va_q[1], sn_q);
    s2 = vsn(va_q[2], sn_q);
    c  = 36'(cs_q);
    m_d[0] = vvt(vv_q[0], t_q) + c;
    m_d[1] = vvt(vv_q[1], t_q) - s2;
    m_d[2] = vvt(vv_q[2], t_q) + s1;
    m_d[3] = vvt(vv_q[1], t_q) + s2;
    m_d[4] = vvt(vv_q[3], t_q) + c;
    m_d[5] = vvt(vv_q[4], t_q) - s0;
    m_d[6] = vvt(vv_q[2], t_q) - s1;
    m_d[7] = vvt(vv_q[4], t_q) + s0;
    m_d[8] = vvt(vv_q[5], t_q) + c;
  end

  logic signed [69:0] acc [3];
  logic signed [39:0] rr  [3];
  logic               ov  [3];
  out_item_t          item_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = 70'(pr_q[3*i]) + 70'(pr_q[3*i+1]) + 70'(pr_q[3*i+2])
             + 70'sd536870912;
      rr[i]  = 40'(acc[i] >>> 30);
      ov[i]  = (rr[i] > 40'sd2147483647) || (rr[i] < -40'sd2147483648);
    end
    item_d.rotated_x = ov[0] ? (rr[0][39] ? 32'sh80000000 : 32'sh7fffffff)
                             : rr[0][31:0];
    item_d.rotated_y = ov[1] ? (rr[1][39] ? 32'sh80000000 : 32'sh7fffffff)
                             : rr[1][31:0];
    item_d.rotated_z = ov[2] ? (rr[2][39] ? 32'sh80000000 : 32'sh7fffffff)
                             : rr[2][31:0];
    item_d.saturated = ov[0] | ov[1] | ov[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sn_q <= sn_d;
      cs_q <= cs_d;
      t_q  <= OneQ30 - cs_d;
      vv_q <= vv_d;
      pa_q[0] <= data_i.px;
      pa_q[1] <= data_i.py;
      pa_q[2] <= data_i.pz;
      va_q[0] <= data_i.vx;
      va_q[1] <= data_i.vy;
      va_q[2] <= data_i.vz;
      m_q  <= m_d;
      pb_q <= pa_q;
      for (int k = 0; k < 9; k++) begin
        pr_q[k] <= 68'(m_q[k]) * 68'(pb_q[k % 3]);
      end
      item_q <= item_d;
    end
  end

  assign valid_o = vld_q[3];
  assign item_o  = item_q;
endmodule
`default_nettype wire

FILE: verif/axis_angle_point_rotation_core_tb.sv
`timescale 1ns / 1ps
module axis_angle_point_rotation_core_tb;
  import aapr_pkg::*;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned Latency = CordicSteps + 6;
  localparam int unsigned RandomItems = 1530;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_item_t in_item_i;
  logic out_valid_o;
  logic out_stall_i;
  out_item_t out_item_o;

  in_item_t pending_q[$];
  out_item_t rotated_q[$];
  int unsigned mismatches;
  int unsigned sent_count;
  bit stim_done;
  bit drain_hold;

  axis_angle_point_rotation_core #(.CORDIC_STEPS(CordicSteps)) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_item_i(in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o(out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // floor(v / 2^s)
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_shift(longint v, int s);
    return floor_shift(v + (64'sd1 <<< (s - 1)), s);
  endfunction

  function automatic longint atan_entry(int i);
    longint tbl[24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                        33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
                        524287, 262143, 131071, 65535, 32767, 16383, 8191,
                        4095, 2047, 1023, 511, 255, 127};
    return tbl[i];
  endfunction

  // Exact floor((sum m*p + 2^29) / 2^30), split to stay inside 64 bits.
  function automatic longint dot_row(longint m[3], longint p[3]);
    longint hi_sum;
    longint lo_sum;
    longint ph;
    longint qh;
    hi_sum = 0;
    lo_sum = 0;
    for (int j = 0; j < 3; j++) begin
      ph = floor_shift(p[j], 16);
      hi_sum += m[j] * ph;
      lo_sum += m[j] * (p[j] - ph * 65536);
    end
    qh = floor_shift(hi_sum, 14);
    return qh + round_shift((hi_sum - qh * 16384) * 65536 + lo_sum, 30);
  endfunction

  function automatic out_item_t rotate_point(in_item_t it);
    longint p[3];
    longint v[3];
    longint a;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint t;
    longint vs[3];
    longint vv[3][3];
    longint m[3][3];
    longint r;
    bit flip;
    out_item_t res;
    p = '{it.point_x, it.point_y, it.point_z};
    v = '{it.axis_x, it.axis_y, it.axis_z};
    a = longint'(it.angle) % longint'(TurnUnits);
    flip = 1'b0;
    if (a < 0) a += longint'(TurnUnits);
    if (a > longint'(HalfTurnUnits)) a -= longint'(TurnUnits);
    if (a > longint'(QuarterTurnUnits)) begin
      a -= longint'(HalfTurnUnits);
      flip = 1'b1;
    end else if (a < -longint'(QuarterTurnUnits)) begin
      a += longint'(HalfTurnUnits);
      flip = 1'b1;
    end
    z = floor_shift(a * 74961321 + 128, 8);
    x = 652032874;
    y = 0;
    for (int i = 0; i < CordicSteps && i < 24; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_entry(i);
      end else begin
        x += dx;
        y -= dy;
        z += atan_entry(i);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    t = 64'sd1073741824 - x;
    for (int i = 0; i < 3; i++) begin
      vs[i] = round_shift(v[i] * y, 14);
      for (int j = 0; j < 3; j++) vv[i][j] = round_shift(v[i] * v[j] * t, 28);
    end
    m[0] = '{vv[0][0] + x, vv[0][1] - vs[2], vv[0][2] + vs[1]};
    m[1] = '{vv[1][0] + vs[2], vv[1][1] + x, vv[1][2] - vs[0]};
    m[2] = '{vv[2][0] - vs[1], vv[2][1] + vs[0], vv[2][2] + x};
    res.saturated = 1'b0;
    for (int i = 0; i < 3; i++) begin
      r = dot_row(m[i], p);
      if (r > 64'sd2147483647) begin
        r = 64'sd2147483647;
        res.saturated = 1'b1;
      end else if (r < -64'sd2147483648) begin
        r = -64'sd2147483648;
        res.saturated = 1'b1;
      end
      if (i == 0) res.rotated_x = r[31:0];
      else if (i == 1) res.rotated_y = r[31:0];
      else res.rotated_z = r[31:0];
    end
    return res;
  endfunction

  function automatic logic [15:0] pick_axis();
    case ($urandom_range(0, 5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'sd0;
      3: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 200 << 16)) - (100 << 16));
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.point_x = pick_coord();
    it.point_y = pick_coord();
    it.point_z = pick_coord();
    it.axis_x = pick_axis();
    it.axis_y = pick_axis();
    it.axis_z = pick_axis();
    case ($urandom_range(0, 3))
      0: it.angle = 16'($urandom);
      default: it.angle = 16'($signed($urandom_range(0, 46080)) - 23040);
    endcase
    return it;
  endfunction

  function automatic in_item_t make_item(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                         logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                                         logic [15:0] ang);
    in_item_t it;
    it.point_x = px;
    it.point_y = py;
    it.point_z = pz;
    it.axis_x = ax;
    it.axis_y = ay;
    it.axis_z = az;
    it.angle = ang;
    return it;
  endfunction

  task automatic queue_item(input in_item_t it);
    pending_q.insert(pending_q.size(), it);
  endtask

  initial begin
    logic [31:0] one;
    one = 32'h00010000;
    // single-axis turns, quadrant edges, full turn, beyond a turn
    queue_item(make_item(one, one, one, 16'sd16384, '0, '0, 16'sd5760));
    queue_item(make_item(one, one, one, '0, 16'sd16384, '0, -16'sd5760));
    queue_item(make_item(one, one, one, '0, '0, 16'sd16384, 16'sd11520));
    queue_item(make_item(one, -one, one, '0, '0, -16'sd16384, 16'sd23040));
    queue_item(make_item(one, one, -one, 16'sd16384, '0, '0, -16'sd23040));
    queue_item(make_item(one, 2 * one, 3 * one, '0, 16'sd16384, '0, 16'sd5761));
    queue_item(make_item(one, 2 * one, 3 * one, '0, 16'sd16384, '0, -16'sd5761));
    queue_item(make_item(one, 2 * one, 3 * one, 16'sd9459, 16'sd9459, 16'sd9459,
                         16'sd7680));
    queue_item(make_item(one, one, one, '0, '0, 16'sd16384, 16'h7fff));
    queue_item(make_item(one, one, one, '0, '0, 16'sd16384, 16'h8000));
    queue_item(make_item(one, one, one, 16'h7fff, 16'h8000, 16'h7fff, 16'sd1000));
    queue_item(make_item(one, one, one, '0, '0, '0, 16'sd3000));
    // overflow toward both rails
    queue_item(make_item(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                         '0, '0, 16'sd16384, 16'sd2880));
    queue_item(make_item(32'h80000000, 32'h80000000, 32'h80000000,
                         '0, '0, 16'sd16384, 16'sd2880));
    queue_item(make_item(32'h7fffffff, 32'h80000000, '0, '0, '0, '0, '0));
    queue_item(make_item(32'hffffffff, 32'hffffffff, 32'hffffffff,
                         16'hffff, 16'hffff, 16'hffff, 16'hffff));
    queue_item(make_item('0, '0, '0, 16'sd16384, '0, '0, 16'sd1));
    for (int i = 0; i < RandomItems; i++) queue_item(random_item());
  end

  initial begin
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Sender: bursts and gaps; one pause for a full drain midway.
  int burst_left;
  int gap_left;
  bit drained_once;

  // Accept is sampled at the rising edge, then the next item is driven.
  logic accepted;
  always @(posedge clk_i) begin
    accepted <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      rotated_q.insert(rotated_q.size(), rotate_point(in_item_i));
      sent_count <= sent_count + 1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !accepted) begin
        // stalled item holds
      end else if (drain_hold) begin
        in_valid_i <= 1'b0;
        if (rotated_q.size() == 0) drain_hold <= 1'b0;
      end else if (!drained_once && sent_count == 800) begin
        in_valid_i <= 1'b0;
        drained_once <= 1'b1;
        drain_hold <= 1'b1;
      end else if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_q.size() == 0) begin
        in_valid_i <= 1'b0;
        stim_done <= 1'b1;
      end else begin
        in_valid_i <= 1'b1;
        in_item_i <= pending_q.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Receiver: own stall pattern plus one long hold-off.
  int stall_mode;
  int mode_left;
  int hold_left;
  bit long_hold_done;
  initial begin
    out_stall_i = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    sent_count = 0;
    stim_done = 1'b0;
    drain_hold = 1'b0;
    drained_once = 1'b0;
    burst_left = 0;
    gap_left = 0;
    stall_mode = 0;
    mode_left = 0;
    hold_left = 0;
    long_hold_done = 1'b0;
    accepted = 1'b0;
    mismatches = 0;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!long_hold_done && sent_count >= 300) begin
        long_hold_done <= 1'b1;
        hold_left <= 3 * Latency + 40;
        out_stall_i <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        if (mode_left <= 0) begin
          stall_mode <= $urandom_range(0, 3);
          mode_left <= $urandom_range(10, 80);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (stall_mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 1) == 0);
          default: out_stall_i <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    out_item_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (rotated_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result item %h", out_item_o);
      end else begin
        exp_res = rotated_q.pop_front();
        if (out_item_o.rotated_x !== exp_res.rotated_x
            || out_item_o.rotated_y !== exp_res.rotated_y
            || out_item_o.rotated_z !== exp_res.rotated_z
            || out_item_o.saturated !== exp_res.saturated) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: exp x=%h y=%h z=%h sat=%b got x=%h y=%h z=%h sat=%b",
                     exp_res.rotated_x, exp_res.rotated_y, exp_res.rotated_z,
                     exp_res.saturated, out_item_o.rotated_x, out_item_o.rotated_y,
                     out_item_o.rotated_z, out_item_o.saturated);
        end
      end
    end
  end

  initial begin
    wait (stim_done && rotated_q.size() == 0);
    repeat (Latency + 10) @(posedge clk_i);
    if (mismatches == 0) $display("** axis_angle_point_rotation_core: PASSED **");
    else $display("** axis_angle_point_rotation_core: FAILED **");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** axis_angle_point_rotation_core: FAILED **");
    $finish;
  end

endmodule

FILE: filelist.f
sv/aapr_pkg.sv
sv/aapr_cordic_cell.sv
sv/aapr_matrix.sv
sv/axis_angle_point_rotation_core.sv
verif/axis_angle_point_rotation_core_tb.sv
